// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/i2cm_pkg.sv =====
//------------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master transaction engine.
//------------------------------------------------------------------------------
`default_nettype none
package i2cm_pkg;
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_SUPPLY = 2'd2;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BUSY = 3'd1;
	localparam logic [2:0] ST_DONE = 3'd2;
	localparam logic [2:0] ST_ACKERR = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;

	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam int unsigned BYTE_BITS = 8;

	localparam int unsigned REG_WAIT_LIMIT = 0;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] slave_address;
		logic [7:0] write_count;
		logic [7:0] read_count;
		logic [7:0] write_byte;
		logic       scl_in;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_pull_low;
		logic       sda_pull_low;
		logic       byte_wanted;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       read_last;
		logic [2:0] status;
	} out_item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/i2cm_stream_if.sv =====
//------------------------------------------------------------------------------
// i2cm_stream_if
// Valid/ready channel carrying one beat of a given payload type.
//------------------------------------------------------------------------------
`default_nettype none
interface i2cm_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/i2cm_apb_regs.sv =====
//------------------------------------------------------------------------------
// i2cm_apb_regs
// APB register file holding the wait limit.
//------------------------------------------------------------------------------
`default_nettype none
module i2cm_apb_regs
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [7:0]  wait_limit
);
	logic [7:0] wait_limit_q;

	assign pready = 1'b1;
	assign wait_limit = wait_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_limit_q <= 8'hff;
		end else if (psel && penable && pwrite && paddr == 2'(REG_WAIT_LIMIT * 4)) begin
			wait_limit_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == 2'(REG_WAIT_LIMIT * 4)) prdata = {24'd0, wait_limit_q};
	end
endmodule
`default_nettype wire

// ===== hw/rtl/i2cm_core.sv =====
//------------------------------------------------------------------------------
// i2cm_core
// Bus sequencer: one micro-operation per accepted beat, registered result.
//------------------------------------------------------------------------------
`default_nettype none
module i2cm_core
	import i2cm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic [7:0] wait_limit,
	i2cm_stream_if.sink    in_ch,
	i2cm_stream_if.source  out_ch
);
	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		PH_IDLE, PH_START, PH_ADDR, PH_WAIT_BYTE, PH_WDATA, PH_READ, PH_STOP, PH_CLOSE
	} phase_t;
	typedef enum logic [3:0] {
		OP_SCL_LO, OP_SCL_HI, OP_SDA_LO, OP_SDA_HI, OP_SDA_BIT, OP_SDA_ACK,
		OP_DELAY, OP_REL_DELAY, OP_SAMPLE
	} op_t;

	phase_t     phase_q, ph_n;
	logic [5:0] step_q, step_n;
	logic [7:0] shift_q, shift_n, writes_q, writes_n, reads_q, reads_n, wait_q, wait_n;
	logic [6:0] addr_q, addr_n;
	logic       tmo_q, tmo_n, scl_q, scl_n, sda_q, sda_n;
	logic [2:0] last_q, last_n;
	logic       out_valid_q;
	out_item_t  out_q, res;
	in_item_t   it;
	logic       take;
	op_t        op;
	logic [2:0] m5, m4;
	logic [5:0] bm;
	logic       lw_on, lw_scl, lw_lvl, smp, done;
	logic [7:0] wait_inc;

	function automatic logic [2:0] mod5(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (r >= 6'd40) r = r - 6'd40;
		if (r >= 6'd20) r = r - 6'd20;
		if (r >= 6'd10) r = r - 6'd10;
		if (r >= 6'd5) r = r - 6'd5;
		return r[2:0];
	endfunction

	assign it = in_ch.data;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_comb begin
		m5 = mod5(step_q);
		m4 = 3'(step_q[1:0]);
		op = OP_DELAY;
		unique case (phase_q)
			PH_START: begin
				bm = (step_q < 6'd5) ? step_q : 6'd4;
				unique case (bm[2:0])
					3'd0: op = OP_SCL_HI;
					3'd1: op = OP_SDA_HI;
					3'd3: op = OP_SDA_LO;
					default: op = OP_DELAY;
				endcase
			end
			PH_STOP: begin
				bm = (step_q < 6'd7) ? step_q : 6'd6;
				unique case (bm[2:0])
					3'd0: op = OP_SCL_LO;
					3'd2: op = OP_SDA_LO;
					3'd3: op = OP_SCL_HI;
					3'd5: op = OP_SDA_HI;
					default: op = OP_DELAY;
				endcase
			end
			PH_ADDR, PH_WDATA: begin
				bm = step_q - 6'd40;
				if (step_q < 6'd40) begin
					unique case (m5)
						3'd0: op = OP_SCL_LO;
						3'd2: op = OP_SDA_BIT;
						3'd3: op = OP_SCL_HI;
						default: op = OP_DELAY;
					endcase
				end else begin
					unique case ((bm < 6'd4) ? bm[1:0] : 2'd3)
						2'd0: op = OP_SCL_LO;
						2'd1: op = OP_REL_DELAY;
						2'd2: op = OP_SCL_HI;
						default: op = OP_SAMPLE;
					endcase
				end
			end
			PH_READ: begin
				bm = step_q - 6'd32;
				if (step_q < 6'd32) begin
					unique case (m4[1:0])
						2'd0: op = OP_SCL_LO;
						2'd1: op = OP_REL_DELAY;
						2'd2: op = OP_SCL_HI;
						default: op = OP_SAMPLE;
					endcase
				end else begin
					unique case ((bm < 6'd5) ? bm[2:0] : 3'd4)
						3'd0: op = OP_SCL_LO;
						3'd2: op = OP_SDA_ACK;
						3'd3: op = OP_SCL_HI;
						default: op = OP_DELAY;
					endcase
				end
			end
			default: bm = '0;
		endcase
	end

	always_comb begin
		ph_n = phase_q; step_n = step_q; shift_n = shift_q; addr_n = addr_q;
		writes_n = writes_q; reads_n = reads_q; wait_n = wait_q; tmo_n = tmo_q;
		last_n = last_q; scl_n = scl_q; sda_n = sda_q;
		res = '0;
		lw_on = 1'b0; lw_scl = 1'b0; lw_lvl = 1'b0; smp = 1'b0; done = 1'b1;
		wait_inc = wait_q + 8'd1;
		if (it.command == CMD_BEGIN) begin
			if (phase_q == PH_IDLE) begin
				addr_n = it.slave_address; writes_n = it.write_count;
				reads_n = it.read_count; tmo_n = 1'b0; wait_n = '0; step_n = '0;
				scl_n = 1'b0; sda_n = 1'b0; ph_n = PH_START; last_n = ST_BUSY;
			end
		end else if (it.command == CMD_SUPPLY) begin
			if (phase_q == PH_WAIT_BYTE) begin
				shift_n = it.write_byte; ph_n = PH_WDATA; step_n = '0;
			end
		end else if (phase_q == PH_CLOSE) begin
			scl_n = 1'b0; sda_n = 1'b0; ph_n = PH_IDLE;
		end else if (phase_q != PH_IDLE && phase_q != PH_WAIT_BYTE) begin
			unique case (op)
				OP_SCL_LO: begin lw_on = 1'b1; lw_scl = 1'b1; lw_lvl = 1'b0; end
				OP_SCL_HI: begin lw_on = 1'b1; lw_scl = 1'b1; lw_lvl = 1'b1; end
				OP_SDA_LO: begin lw_on = 1'b1; lw_lvl = 1'b0; end
				OP_SDA_HI: begin lw_on = 1'b1; lw_lvl = 1'b1; end
				OP_SDA_BIT: begin lw_on = 1'b1; lw_lvl = |(shift_q & MSB_MASK); end
				OP_SDA_ACK: begin lw_on = 1'b1; lw_lvl = !(reads_q > 8'd1); end
				OP_REL_DELAY: sda_n = 1'b0;
				OP_SAMPLE: smp = 1'b1;
				default: ;
			endcase
			if (smp) shift_n = {shift_q[6:0], it.sda_in};
			if (lw_on) begin
				if (lw_scl) scl_n = !lw_lvl; else sda_n = !lw_lvl;
				if ((lw_scl ? it.scl_in : it.sda_in) == lw_lvl) begin
					wait_n = '0;
				end else if (wait_inc == wait_limit) begin
					tmo_n = 1'b1; wait_n = '0;
				end else begin
					wait_n = wait_inc; done = 1'b0;
				end
			end
			if (done) begin
				step_n = step_q + 6'd1;
				unique case (phase_q)
					PH_START: if (step_q >= 6'd4) begin
						shift_n = {addr_q, writes_q == 8'd0}; ph_n = PH_ADDR; step_n = '0;
					end
					PH_ADDR, PH_WDATA: begin
						if (step_q < 6'(5 * BYTE_BITS) && m5 == 3'd4) shift_n = {shift_q[6:0], 1'b0};
						if (step_q >= 6'd43) begin
							step_n = '0;
							if (shift_n[0]) begin
								last_n = ST_ACKERR; ph_n = PH_CLOSE;
							end else if (phase_q == PH_ADDR) begin
								if (writes_q != 8'd0) ph_n = PH_WAIT_BYTE;
								else if (reads_q != 8'd0) begin ph_n = PH_READ; shift_n = '0; end
								else ph_n = PH_STOP;
							end else begin
								writes_n = writes_q - 8'd1;
								ph_n = (writes_n != 8'd0) ? PH_WAIT_BYTE : PH_STOP;
							end
						end
					end
					PH_READ: begin
						if (step_q == 6'd31) begin
							res.read_valid = 1'b1; res.read_byte = shift_n;
							res.read_last = reads_q == 8'd1;
						end else if (step_q >= 6'd36) begin
							step_n = '0; shift_n = '0; reads_n = reads_q - 8'd1;
							if (reads_n == 8'd0) ph_n = PH_STOP;
						end
					end
					PH_STOP: if (step_q >= 6'd6) begin
						step_n = '0;
						if (reads_q != 8'd0) ph_n = PH_START;
						else begin
							last_n = tmo_q ? ST_TIMEOUT : ST_DONE; ph_n = PH_CLOSE;
						end
					end
					default: ;
				endcase
			end
		end
		res.scl_pull_low = scl_n;
		res.sda_pull_low = sda_n;
		res.byte_wanted = ph_n == PH_WAIT_BYTE;
		res.status = (ph_n == PH_IDLE) ? last_n : ST_BUSY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; step_q <= '0; shift_q <= '0; addr_q <= '0;
			writes_q <= '0; reads_q <= '0; wait_q <= '0; tmo_q <= 1'b0;
			last_q <= ST_IDLE; scl_q <= 1'b0; sda_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= ph_n; step_q <= step_n; shift_q <= shift_n; addr_q <= addr_n;
				writes_q <= writes_n; reads_q <= reads_n; wait_q <= wait_n; tmo_q <= tmo_n;
				last_q <= last_n; scl_q <= scl_n; sda_q <= sda_n;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end

	`ASSERT_NEXT(a_out_after_take, clk, arst_n, take, out_valid_q, "beat accepted but no result")
	`ASSERT_IMPL(a_idle_released, clk, arst_n, phase_q == PH_IDLE, !scl_q && !sda_q,
		"idle engine drives a line")
	`ASSERT_IMPL(a_idle_wait_clear, clk, arst_n, phase_q == PH_IDLE,
		wait_q == 8'd0, "wait counter left running in idle")
endmodule
`default_nettype wire

// ===== hw/rtl/i2c_master_transaction_engine.sv =====
//------------------------------------------------------------------------------
// i2c_master_transaction_engine
// I2C master with 7-bit addressing driven one bus tick per input beat.
//------------------------------------------------------------------------------
// Each input beat is one bus delay tick with pin samples, or a command; every
// beat yields one result beat in the cycle after it is taken, and a new beat
// is taken every cycle while the result register is free or being drained. The
// single sequencer step between the input handshake and the result register
// sets this rate of one beat per cycle.
`default_nettype none
module i2c_master_transaction_engine
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	i2cm_stream_if.sink      in_ch,
	i2cm_stream_if.source    out_ch
);
	logic [7:0] wait_limit;

	i2cm_apb_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.wait_limit
	);

	i2cm_core u_core (
		.clk, .arst_n, .wait_limit, .in_ch, .out_ch
	);
endmodule
`default_nettype wire
